// ===== rtl/core/ttcb_pkg.sv =====
// Package for the timed target claim buffer: item codes, widths and word types.
// No dependencies; the cell and the buffer import it, and the interface takes its payload types.
`timescale 1ns / 1ps
`default_nettype none
package ttcb_pkg;
	localparam int TIME_W = 32;
	localparam int KIND_W = 3;
	localparam int PCOUNT_W = 3;
	localparam int TCOUNT_W = 9;
	localparam int DEF_TABLE_DEPTH = 256;
	localparam int DEF_MAX_PENDING = 4;
	localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd200000;
	localparam logic [TIME_W-1:0] HOLD_RESET = 32'd500000;

	localparam logic [KIND_W-1:0] KIND_CLEAR_TARGETS = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ADD_TARGET = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RESET_USED = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR_PENDING = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TRY_BUFFER = 3'd4;
	localparam logic [KIND_W-1:0] KIND_TAKE_DUE = 3'd5;

	localparam logic CFG_WINDOW = 1'b0;
	localparam logic CFG_HOLD = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TIME_W-1:0] song_time;
		logic [TIME_W-1:0] target_time;
		logic second_player;
	} in_word_t;

	typedef struct packed {
		logic accepted;
		logic released_player;
		logic [PCOUNT_W-1:0] pending_count;
		logic [TCOUNT_W-1:0] target_count;
		logic table_full;
	} out_word_t;

	// Command broadcast from the controller to every cell for one cycle.
	typedef struct packed {
		logic clear_all;
		logic clear_used;
		logic insert;
		logic claim;
		logic [TIME_W-1:0] ins_time;
	} cell_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/core/ttcb_if.sv =====
// Valid/ready channel interface carrying one word of type WORD_T.
// Depends on nothing; payload types come from ttcb_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ttcb_if #(parameter type WORD_T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	WORD_T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ttcb_cell.sv =====
// One target cell: a time, a valid mark and a consumed mark; shifts right on insert.
// Depends on ttcb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ttcb_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire ttcb_pkg::cell_cmd_t cmd,
	input wire logic left_valid,
	input wire logic left_keeps,
	input wire logic [ttcb_pkg::TIME_W-1:0] left_time,
	input wire logic left_used,
	input wire logic claim_sel,
	output logic valid,
	output logic keeps,
	output logic [ttcb_pkg::TIME_W-1:0] cell_time,
	output logic used
);
	import ttcb_pkg::*;
	logic valid_q, used_q;
	logic [TIME_W-1:0] time_q;
	logic ins_here;
	logic shift_in;

	// Entries are sorted, so the cells with time <= new time form a prefix and keep
	// their entries on an insert.
	assign keeps = valid_q && (time_q <= cmd.ins_time);
	// The new time lands in the first cell that does not keep its entry; every cell
	// past it takes the entry of its left neighbor.
	assign ins_here = left_keeps && !keeps;
	assign shift_in = !left_keeps;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			used_q <= 1'b0;
		end else if (cmd.clear_all) begin
			valid_q <= 1'b0;
		end else if (cmd.clear_used) begin
			used_q <= 1'b0;
		end else if (cmd.insert) begin
			if (shift_in) begin
				valid_q <= left_valid;
				used_q <= left_used;
			end else if (ins_here) begin
				valid_q <= 1'b1;
				used_q <= 1'b0;
			end
		end else if (cmd.claim && claim_sel) begin
			used_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (shift_in) time_q <= left_time;
			else if (ins_here) time_q <= cmd.ins_time;
		end
	end

	assign valid = valid_q;
	assign cell_time = time_q;
	assign used = used_q;
endmodule
`default_nettype wire

// ===== rtl/core/timed_target_claim_buffer.sv =====
// Timed target claim buffer: a sorted chain of target cells plus pending release slots.
// Once the input word is taken, the insert or clear is applied across the cell chain;
// then the cells at or after song time that are still unconsumed are flagged and the
// first flagged cell in each group of sixteen is picked; then the first group is
// picked; then the chosen cell's time is read into a register; then the claim or
// release is committed and the result word is registered and offered. The length of
// this sequence is set by the search through the cell row. At most one item is in
// flight; a new word is taken in the cycle after the result has left the output
// register, so no new word is taken until the last result has gone, and a receiver
// that holds off stalls the input for as long. Adds shift every later cell one place
// right together, so equal times keep arrival order. There is no clearing pass after
// reset: valid marks in each cell reset at once.
`timescale 1ns / 1ps
`default_nettype none
module timed_target_claim_buffer #(
	parameter int TABLE_DEPTH = ttcb_pkg::DEF_TABLE_DEPTH,
	parameter int MAX_PENDING = ttcb_pkg::DEF_MAX_PENDING
) (
	input wire logic clk,
	input wire logic arst_n,
	ttcb_if.sink in_ch,
	ttcb_if.source out_ch,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [ttcb_pkg::TIME_W-1:0] cfg_data
);
	import ttcb_pkg::*;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int SLOT_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
	localparam int PC_W = $clog2(MAX_PENDING + 1);
	localparam int GRP = 16;
	localparam int NGRP = (TABLE_DEPTH + GRP - 1) / GRP;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_APPLY = 3'd1;
	localparam logic [2:0] ST_FLAG = 3'd2;
	localparam logic [2:0] ST_PICK = 3'd3;
	localparam logic [2:0] ST_READ = 3'd4;
	localparam logic [2:0] ST_COMMIT = 3'd5;
	localparam logic [2:0] ST_OUT = 3'd6;

	logic [2:0] state_q;
	in_word_t item_q;
	out_word_t res_q;
	logic [TIME_W-1:0] window_q, hold_q;
	logic [CNT_W-1:0] held_q;
	logic full_q;

	logic [MAX_PENDING-1:0] busy_q;
	logic [TIME_W-1:0] rel_time_q [MAX_PENDING];
	logic [MAX_PENDING-1:0] rel_player_q;

	// Search pipeline.
	logic [GRP*NGRP-1:0] cand, lo_first, first_s1, sel_s2;
	logic [NGRP-1:0] grp_any, grp_any_s1, grp_pick;
	logic any_s2;
	logic [TIME_W-1:0] cand_mux, cand_time_s3;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			hold_q <= HOLD_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_WINDOW) window_q <= cfg_data;
			else hold_q <= cfg_data;
		end
	end

	// Cell chain. Each cell tells its right neighbor whether it keeps its entry.
	cell_cmd_t cmd;
	logic [TABLE_DEPTH-1:0] c_valid, c_keeps, c_used;
	logic [TIME_W-1:0] c_time [TABLE_DEPTH];

	genvar g;
	generate
		for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
			if (g == 0) begin : g_first
				ttcb_cell u_cell (
					.clk(clk), .arst_n(arst_n), .cmd(cmd),
					.left_valid(1'b0), .left_keeps(1'b1),
					.left_time('0), .left_used(1'b0),
					.claim_sel(sel_s2[g]), .valid(c_valid[g]), .keeps(c_keeps[g]),
					.cell_time(c_time[g]), .used(c_used[g])
				);
			end else begin : g_rest
				ttcb_cell u_cell (
					.clk(clk), .arst_n(arst_n), .cmd(cmd),
					.left_valid(c_valid[g-1]), .left_keeps(c_keeps[g-1]),
					.left_time(c_time[g-1]), .left_used(c_used[g-1]),
					.claim_sel(sel_s2[g]), .valid(c_valid[g]), .keeps(c_keeps[g]),
					.cell_time(c_time[g]), .used(c_used[g])
				);
			end
		end
	endgenerate

	// Candidate flags per cell and the first flagged cell of each group of sixteen.
	always_comb begin
		cand = '0;
		for (int k = 0; k < TABLE_DEPTH; k++)
			cand[k] = c_valid[k] && !c_used[k] && (c_time[k] >= item_q.song_time);
	end

	always_comb begin
		lo_first = '0;
		grp_any = '0;
		for (int gi = 0; gi < NGRP; gi++) begin
			grp_any[gi] = |cand[gi*GRP +: GRP];
			for (int b = GRP - 1; b >= 0; b--) begin
				if (cand[gi*GRP + b]) begin
					lo_first[gi*GRP +: GRP] = '0;
					lo_first[gi*GRP + b] = 1'b1;
				end
			end
		end
	end

	// The stages run every cycle; the cells and the item stay put from the apply
	// cycle until the commit, so each stage holds a settled value when it is used.
	always_ff @(posedge clk) begin
		first_s1 <= lo_first;
		grp_any_s1 <= grp_any;
	end

	always_comb begin
		grp_pick = '0;
		for (int gi = NGRP - 1; gi >= 0; gi--) begin
			if (grp_any_s1[gi]) begin
				grp_pick = '0;
				grp_pick[gi] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		any_s2 <= |grp_any_s1;
		for (int gi = 0; gi < NGRP; gi++)
			sel_s2[gi*GRP +: GRP] <= grp_pick[gi] ? first_s1[gi*GRP +: GRP] : '0;
	end

	// One-hot read of the chosen cell's time.
	always_comb begin
		cand_mux = '0;
		for (int k = 0; k < TABLE_DEPTH; k++)
			cand_mux = cand_mux | (c_time[k] & {TIME_W{sel_s2[k]}});
	end

	always_ff @(posedge clk) begin
		cand_time_s3 <= cand_mux;
	end

	// A target past the window ends the search even when it is consumed. The row is
	// sorted, so every target before the candidate fits the window when the candidate
	// itself does.
	logic [TIME_W:0] cand_delay;
	logic claim_ok, full_slots;
	assign cand_delay = {1'b0, cand_time_s3} - {1'b0, item_q.song_time};
	assign full_slots = &busy_q;
	assign claim_ok = (item_q.kind == KIND_TRY_BUFFER) && any_s2 && !full_slots
		&& (cand_delay <= {1'b0, window_q})
		&& (cand_delay != '0) && (cand_delay <= {1'b0, hold_q});

	// Lowest free slot and lowest due slot.
	logic [SLOT_W-1:0] free_idx, due_idx;
	logic due_any;
	always_comb begin
		free_idx = '0;
		due_idx = '0;
		due_any = 1'b0;
		for (int s = MAX_PENDING - 1; s >= 0; s--) begin
			if (!busy_q[s]) free_idx = SLOT_W'(s);
			if (busy_q[s] && item_q.song_time >= rel_time_q[s]) begin
				due_idx = SLOT_W'(s);
				due_any = 1'b1;
			end
		end
	end

	logic take_ok;
	assign take_ok = (item_q.kind == KIND_TAKE_DUE) && due_any;

	logic [PC_W-1:0] busy_next_cnt;
	logic [MAX_PENDING-1:0] busy_next;
	always_comb begin
		busy_next = busy_q;
		if (claim_ok) busy_next[free_idx] = 1'b1;
		if (take_ok) busy_next[due_idx] = 1'b0;
		busy_next_cnt = '0;
		for (int s = 0; s < MAX_PENDING; s++) busy_next_cnt += PC_W'(busy_next[s]);
	end

	always_comb begin
		cmd = '0;
		cmd.ins_time = item_q.target_time;
		if (state_q == ST_APPLY) begin
			cmd.clear_all = (item_q.kind == KIND_CLEAR_TARGETS);
			cmd.clear_used = (item_q.kind == KIND_RESET_USED);
			cmd.insert = (item_q.kind == KIND_ADD_TARGET) && (held_q < CNT_W'(TABLE_DEPTH));
		end
		cmd.claim = (state_q == ST_COMMIT) && claim_ok;
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q <= '0;
			busy_q <= '0;
			full_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					full_q <= (item_q.kind == KIND_ADD_TARGET) &&
						(held_q >= CNT_W'(TABLE_DEPTH));
					unique case (item_q.kind) inside
						KIND_CLEAR_TARGETS: begin
							held_q <= '0;
							busy_q <= '0;
						end
						KIND_ADD_TARGET: begin
							if (held_q < CNT_W'(TABLE_DEPTH)) held_q <= held_q + CNT_W'(1);
						end
						KIND_RESET_USED, KIND_CLEAR_PENDING: busy_q <= '0;
						default: ;
					endcase
					state_q <= ST_FLAG;
				end
				ST_FLAG: state_q <= ST_PICK;
				ST_PICK: state_q <= ST_READ;
				ST_READ: state_q <= ST_COMMIT;
				ST_COMMIT: begin
					busy_q <= busy_next;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ch.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) item_q <= in_ch.data;
		if (state_q == ST_COMMIT) begin
			if (claim_ok) begin
				rel_time_q[free_idx] <= cand_time_s3;
				rel_player_q[free_idx] <= item_q.second_player;
			end
			res_q.accepted <= claim_ok || take_ok;
			res_q.released_player <= take_ok ? rel_player_q[due_idx] : 1'b0;
			res_q.pending_count <= PCOUNT_W'(busy_next_cnt);
			res_q.target_count <= TCOUNT_W'(held_q);
			res_q.table_full <= full_q;
		end
	end

	property p_one_in_flight;
		@(posedge clk) disable iff (!arst_n) out_ch.valid |-> !in_ch.ready;
	endproperty
	a_one_in_flight: assert property (p_one_in_flight) else $error("ready while result held");

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) held_q <= CNT_W'(TABLE_DEPTH);
	endproperty
	a_count_bound: assert property (p_count_bound) else $error("target count overflow");

	property p_out_follows_commit;
		@(posedge clk) disable iff (!arst_n) $rose(out_ch.valid) |-> $past(state_q == ST_COMMIT);
	endproperty
	a_out_follows_commit: assert property (p_out_follows_commit) else $error("result out of order");
endmodule
`default_nettype wire
